[rtl/humidity_sensor_frame_checker_assert.svh]
// assertion macros for the humidity sensor frame checker
// needs nothing else; included by the modules that carry checks
`ifndef HUMIDITY_SENSOR_FRAME_CHECKER_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define HSFC_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("frame checker: same-cycle check failed");

// next-cycle implication, skipped while in reset
`define HSFC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("frame checker: next-cycle check failed");

`endif

[rtl/hsfc_pkg.sv]
// shared types, codes and the crc-8 step for the humidity sensor frame checker
// no dependencies
package hsfc_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FIRST_BAD  = 2'd1;
  localparam logic [1:0] STATUS_SECOND_BAD = 2'd2;

  // position of a byte in its frame
  localparam logic [2:0] POS_FIRST_HI  = 3'd0;
  localparam logic [2:0] POS_FIRST_LO  = 3'd1;
  localparam logic [2:0] POS_FIRST_CRC = 3'd2;
  localparam logic [2:0] POS_SECOND_HI = 3'd3;
  localparam logic [2:0] POS_SECOND_LO = 3'd4;
  localparam logic [2:0] POS_LAST      = 3'd5;

  // frame mode register values
  localparam logic MODE_MEASURE  = 1'b0;
  localparam logic MODE_IDENTITY = 1'b1;

  // crc-8 parameters
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion scale factors
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUMID_SCALE = 14'd10000;

  typedef logic [1:0] status_t;

  // one byte through the crc, msb first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/humidity_sensor_frame_checker.sv]
// humidity sensor frame checker: byte stream in, checked and scaled frame out
// depends on hsfc_pkg and humidity_sensor_frame_checker_assert.svh
//
// Usage
//   s_axis carries received sensor bytes, one item per byte; tuser set marks
//   the first byte of a frame and restarts assembly at once (a partial frame
//   is dropped). cfg_we/cfg_data set frame_mode: 0 gives six-byte measurement
//   frames, 1 gives three-byte identity frames; a write drops any partial frame.
//   m_axis gives one item per complete frame: the raw words, temperature in
//   hundredths of a degree and humidity in hundredths of a percent, with the
//   crc status in tuser. Results are kept on crc failure; only status marks it.
// Timing
//   one byte accepted per cycle while s_axis_tready is high; the crc step and
//   both scaling multiplies sit between the frame state registers and the
//   result register, which loads as the closing byte is accepted.
//   A stalled m_axis holds the result; a spare register takes the next result,
//   and s_axis_tready drops only while that spare is full (it is registered).
// Reset
//   rst (synchronous) empties both result registers, selects measurement mode
//   and restarts frame assembly.
`include "humidity_sensor_frame_checker_assert.svh"

module humidity_sensor_frame_checker (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_data,       // frame_mode
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  // frame result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] raw_first, [31:16] raw_second,
                                      // [46:32] temp_centi, [60:47] humid_centi, zero fill
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // frame state
  logic        frame_mode;
  logic [2:0]  byte_index;
  logic [7:0]  crc_accum;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic        first_bad;

  logic [2:0]  byte_index_next;
  logic [7:0]  crc_accum_next;
  logic [15:0] first_word_next;
  logic [15:0] second_word_next;
  logic        first_bad_next;

  // result register
  logic                 res_valid;
  hsfc_pkg::status_t    res_status;
  logic [15:0]          res_raw_first;
  logic [15:0]          res_raw_second;
  logic signed [14:0]   res_temp;
  logic [13:0]          res_humid;

  // spare result register, filled while the output item waits
  logic                 spare_valid;
  hsfc_pkg::status_t    spare_status;
  logic [15:0]          spare_raw_first;
  logic [15:0]          spare_raw_second;
  logic signed [14:0]   spare_temp;
  logic [13:0]          spare_humid;

  logic                 in_fire;
  logic                 out_free;
  logic [2:0]           pos;
  logic [7:0]           rx;
  logic [7:0]           crc_start;
  logic [7:0]           crc_stepped;
  logic                 crc_bad;
  logic                 produce;
  hsfc_pkg::status_t    new_status;
  logic [15:0]          new_raw_second;
  logic [14:0]          new_temp;
  logic [13:0]          new_humid;
  logic [30:0]          temp_prod;
  logic [29:0]          humid_prod;

  assign s_axis_tready = !spare_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !res_valid || m_axis_tready;
  assign rx            = s_axis_tdata;

  // position of this byte: frame start or an out-of-range index restart the frame
  assign pos = (s_axis_tuser || (byte_index > hsfc_pkg::POS_LAST)) ?
               hsfc_pkg::POS_FIRST_HI : byte_index;

  // crc of the current word, seeded afresh on the high byte of each word
  assign crc_start   = (pos == hsfc_pkg::POS_FIRST_HI || pos == hsfc_pkg::POS_SECOND_HI) ?
                       hsfc_pkg::CRC_INIT : crc_accum;
  assign crc_stepped = hsfc_pkg::crc8_step(crc_start, rx);
  assign crc_bad     = (crc_accum != rx);

  // scaling: floor(scale * raw / 65536)
  assign temp_prod  = 31'(hsfc_pkg::TEMP_SCALE) * 31'(first_word);
  assign humid_prod = 30'(hsfc_pkg::HUMID_SCALE) * 30'(second_word);

  // frame sequencing and result forming
  always_comb begin
    byte_index_next  = pos + 3'd1;
    crc_accum_next   = crc_stepped;
    first_word_next  = first_word;
    second_word_next = second_word;
    first_bad_next   = s_axis_tuser ? 1'b0 : first_bad;
    produce          = 1'b0;
    new_status       = hsfc_pkg::STATUS_OK;
    new_raw_second   = second_word;
    new_temp         = temp_prod[30:16] - hsfc_pkg::TEMP_OFFSET;
    new_humid        = humid_prod[29:16];
    unique case (pos)
      hsfc_pkg::POS_FIRST_HI: begin
        first_word_next = {rx, 8'h00};
        first_bad_next  = 1'b0;
      end
      hsfc_pkg::POS_FIRST_LO: begin
        first_word_next = {first_word[15:8], rx};
      end
      hsfc_pkg::POS_FIRST_CRC: begin
        crc_accum_next = hsfc_pkg::CRC_INIT;
        first_bad_next = crc_bad;
        if (frame_mode == hsfc_pkg::MODE_IDENTITY) begin
          produce         = 1'b1;
          new_status      = crc_bad ? hsfc_pkg::STATUS_FIRST_BAD : hsfc_pkg::STATUS_OK;
          new_raw_second  = 16'd0;
          new_temp        = 15'd0;
          new_humid       = 14'd0;
          byte_index_next = hsfc_pkg::POS_FIRST_HI;
          first_bad_next  = 1'b0;
        end
      end
      hsfc_pkg::POS_SECOND_HI: begin
        second_word_next = {rx, 8'h00};
      end
      hsfc_pkg::POS_SECOND_LO: begin
        second_word_next = {second_word[15:8], rx};
      end
      hsfc_pkg::POS_LAST: begin
        produce         = 1'b1;
        new_status      = first_bad ? hsfc_pkg::STATUS_FIRST_BAD :
                          (crc_bad ? hsfc_pkg::STATUS_SECOND_BAD : hsfc_pkg::STATUS_OK);
        crc_accum_next  = hsfc_pkg::CRC_INIT;
        byte_index_next = hsfc_pkg::POS_FIRST_HI;
        first_bad_next  = 1'b0;
      end
      default: begin
        byte_index_next = hsfc_pkg::POS_FIRST_HI;
        crc_accum_next  = hsfc_pkg::CRC_INIT;
        first_bad_next  = 1'b0;
      end
    endcase
  end

  // frame state registers; a mode write drops any partial frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode  <= hsfc_pkg::MODE_MEASURE;
      byte_index  <= hsfc_pkg::POS_FIRST_HI;
      crc_accum   <= hsfc_pkg::CRC_INIT;
      first_word  <= 16'd0;
      second_word <= 16'd0;
      first_bad   <= 1'b0;
    end else if (cfg_we) begin
      frame_mode <= cfg_data;
      byte_index <= hsfc_pkg::POS_FIRST_HI;
      crc_accum  <= hsfc_pkg::CRC_INIT;
      first_bad  <= 1'b0;
    end else if (in_fire) begin
      byte_index  <= byte_index_next;
      crc_accum   <= crc_accum_next;
      first_word  <= first_word_next;
      second_word <= second_word_next;
      first_bad   <= first_bad_next;
    end
  end

  // result and spare valid flags; the spare drains into the output first
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (in_fire && produce) begin
      if (out_free) begin
        res_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (out_free) begin
      res_valid   <= spare_valid;
      spare_valid <= 1'b0;
    end
  end

  // result and spare payload
  always_ff @(posedge clk) begin
    if (in_fire && produce && out_free) begin
      res_status     <= new_status;
      res_raw_first  <= first_word_next;
      res_raw_second <= new_raw_second;
      res_temp       <= new_temp;
      res_humid      <= new_humid;
    end else if (in_fire && produce) begin
      spare_status     <= new_status;
      spare_raw_first  <= first_word_next;
      spare_raw_second <= new_raw_second;
      spare_temp       <= new_temp;
      spare_humid      <= new_humid;
    end else if (out_free && spare_valid) begin
      res_status     <= spare_status;
      res_raw_first  <= spare_raw_first;
      res_raw_second <= spare_raw_second;
      res_temp       <= spare_temp;
      res_humid      <= spare_humid;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_status;
  assign m_axis_tdata  = {3'b000, res_humid, res_temp, res_raw_second, res_raw_first};

  // checks
  `HSFC_ASSERT_NOW(a_index_range, clk, rst, 1'b1, byte_index <= hsfc_pkg::POS_LAST)
  `HSFC_ASSERT_NOW(a_identity_short, clk, rst, frame_mode == hsfc_pkg::MODE_IDENTITY,
                   byte_index <= hsfc_pkg::POS_FIRST_CRC)
  `HSFC_ASSERT_NEXT(a_start_restarts, clk, rst, in_fire && s_axis_tuser && !cfg_we,
                    byte_index == hsfc_pkg::POS_FIRST_LO)
  `HSFC_ASSERT_NEXT(a_result_shown, clk, rst, in_fire && produce, m_axis_tvalid)
  `HSFC_ASSERT_NOW(a_status_code, clk, rst, m_axis_tvalid,
                   m_axis_tuser <= hsfc_pkg::STATUS_SECOND_BAD)
  `HSFC_ASSERT_NOW(a_spare_behind, clk, rst, spare_valid, res_valid)

endmodule

[test/humidity_sensor_frame_checker_tb.sv]
// self-checking testbench for humidity_sensor_frame_checker: directed frames, then random frames
// depends on hsfc_pkg and the rtl top level; checks results against the table or a bench predictor
`timescale 1ns / 1ps

module humidity_sensor_frame_checker_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_BYTES    = 104;
  localparam bit ROW_BYTE       = 1'b0;
  localparam bit ROW_MODE       = 1'b1;

  // one checked frame result
  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        raw_first;
    logic [15:0]        raw_second;
    logic signed [14:0] temp;
    logic [13:0]        humid;
  } frame_result_t;

  // one line of the directed table: a byte item or a mode write
  typedef struct packed {
    bit            is_cfg;
    logic [7:0]    data;
    bit            start;
    bit            typed;
    frame_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0;    // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [15:0] raw_first, [31:16] raw_second,
                                       // [46:32] temp_centi, [60:47] humid_centi
  logic [1:0]  m_axis_tuser;           // [1:0] status

  // predictor state
  logic        fc_mode = hsfc_pkg::MODE_MEASURE;
  logic [2:0]  fc_pos = hsfc_pkg::POS_FIRST_HI;
  logic [7:0]  fc_crc = hsfc_pkg::CRC_INIT;
  logic [15:0] fc_w1 = '0;
  logic [15:0] fc_w2 = '0;
  logic        fc_bad1 = 1'b0;

  frame_result_t expected_frames[$];
  plan_row_t     plan[$];
  bit            steady = 1'b0;
  int            errors = 0;
  int            bytes_sent = 0;
  int            results_seen = 0;
  int            mode_writes = 0;
  int            idle_cycles = 0;

  humidity_sensor_frame_checker DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // crc-8, poly 0x31, msb first
  function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ hsfc_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic frame_result_t mk(input logic [1:0] s, input logic [15:0] a,
                                       input logic [15:0] b, input int tc, input int hc);
    frame_result_t r;
    r.status     = s;
    r.raw_first  = a;
    r.raw_second = b;
    r.temp       = tc[14:0];
    r.humid      = hc[13:0];
    return r;
  endfunction

  function automatic plan_row_t row(input bit is_cfg, input logic [7:0] d, input bit st = 1'b0,
                                    input bit typed = 1'b0, input frame_result_t want = '0);
    plan_row_t p;
    p.is_cfg = is_cfg;
    p.data   = d;
    p.start  = st;
    p.typed  = typed;
    p.want   = want;
    return p;
  endfunction

  // advance the frame predictor by one byte; returns 1 when the byte closes a frame
  function automatic bit frame_step(input logic [7:0] b, input bit st, output frame_result_t r);
    logic [31:0] t;
    logic [31:0] h;
    r = '0;
    if (st || fc_pos > hsfc_pkg::POS_LAST) begin
      fc_pos  = hsfc_pkg::POS_FIRST_HI;
      fc_crc  = hsfc_pkg::CRC_INIT;
      fc_bad1 = 1'b0;
    end
    case (fc_pos)
      hsfc_pkg::POS_FIRST_HI: begin
        fc_w1  = {b, 8'h00};
        fc_crc = crc_byte(hsfc_pkg::CRC_INIT, b);
      end
      hsfc_pkg::POS_FIRST_LO: begin
        fc_w1[7:0] = b;
        fc_crc     = crc_byte(fc_crc, b);
      end
      hsfc_pkg::POS_FIRST_CRC: begin
        fc_bad1 = (fc_crc != b);
        fc_crc  = hsfc_pkg::CRC_INIT;
        // identity frame ends after the first word
        if (fc_mode == hsfc_pkg::MODE_IDENTITY) begin
          r.status    = fc_bad1 ? hsfc_pkg::STATUS_FIRST_BAD : hsfc_pkg::STATUS_OK;
          r.raw_first = fc_w1;
          fc_pos      = hsfc_pkg::POS_FIRST_HI;
          fc_bad1     = 1'b0;
          return 1'b1;
        end
      end
      hsfc_pkg::POS_SECOND_HI: begin
        fc_w2  = {b, 8'h00};
        fc_crc = crc_byte(hsfc_pkg::CRC_INIT, b);
      end
      hsfc_pkg::POS_SECOND_LO: begin
        fc_w2[7:0] = b;
        fc_crc     = crc_byte(fc_crc, b);
      end
      default: begin
        // closing crc of a measurement frame: scale both words
        t = (32'(hsfc_pkg::TEMP_SCALE) * fc_w1) >> 16;
        h = (32'(hsfc_pkg::HUMID_SCALE) * fc_w2) >> 16;
        r.status     = fc_bad1 ? hsfc_pkg::STATUS_FIRST_BAD :
                       (fc_crc != b) ? hsfc_pkg::STATUS_SECOND_BAD : hsfc_pkg::STATUS_OK;
        r.raw_first  = fc_w1;
        r.raw_second = fc_w2;
        r.temp       = t[14:0] - hsfc_pkg::TEMP_OFFSET;
        r.humid      = h[13:0];
        fc_pos  = hsfc_pkg::POS_FIRST_HI;
        fc_crc  = hsfc_pkg::CRC_INIT;
        fc_bad1 = 1'b0;
        return 1'b1;
      end
    endcase
    fc_pos = fc_pos + 3'd1;
    return 1'b0;
  endfunction

  // offer one byte item, with random gaps outside the steady phase, and predict once it is taken
  task automatic push_byte(input logic [7:0] b, input bit st, input bit typed = 1'b0,
                           input frame_result_t want = '0);
    frame_result_t r;
    while (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    if (frame_step(b, st, r)) expected_frames.push_back(typed ? want : r);
    bytes_sent++;
  endtask

  // mode write: hold the input off until every result is in, let the block settle, then write
  task automatic set_mode(input logic m);
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we  <= 1'b0;
    fc_mode = m;
    fc_pos  = hsfc_pkg::POS_FIRST_HI;
    fc_crc  = hsfc_pkg::CRC_INIT;
    fc_bad1 = 1'b0;
    mode_writes++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result sink with random back-pressure outside the steady phase
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 21);
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = expected_frames.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("raw_first", want.raw_first, m_axis_tdata[15:0]);
        check_field("raw_second", want.raw_second, m_axis_tdata[31:16]);
        check_field("temp_centi", int'(want.temp), int'($signed(m_axis_tdata[46:32])));
        check_field("humid_centi", want.humid, m_axis_tdata[60:47]);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          ph;
    int          k;
    int          nwords;
    int          len;
    int          pick;
    int          phase_start;
    logic [15:0] w;
    logic [7:0]  c;

    // directed table: extremes, crc failures, restarts and mode writes mid-frame
    plan.push_back(row(ROW_BYTE, 8'h00, 1'b1));
    plan.push_back(row(ROW_BYTE, 8'h00));
    plan.push_back(row(ROW_BYTE, 8'h81));
    plan.push_back(row(ROW_BYTE, 8'h00));
    plan.push_back(row(ROW_BYTE, 8'h00));
    plan.push_back(row(ROW_BYTE, 8'h81, 1'b0, 1'b1,
                       mk(hsfc_pkg::STATUS_OK, 16'h0000, 16'h0000, -4500, 0)));
    // no frame start after a complete frame, both crcs wrong
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'h00));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'h00, 1'b0, 1'b1,
                       mk(hsfc_pkg::STATUS_FIRST_BAD, 16'hFFFF, 16'hFFFF, 12999, 9999)));
    // partial frame dropped by the mode write
    plan.push_back(row(ROW_BYTE, 8'h5A, 1'b1));
    plan.push_back(row(ROW_MODE, 8'(hsfc_pkg::MODE_IDENTITY)));
    plan.push_back(row(ROW_BYTE, 8'h00, 1'b1));
    plan.push_back(row(ROW_BYTE, 8'h00));
    plan.push_back(row(ROW_BYTE, 8'h81, 1'b0, 1'b1,
                       mk(hsfc_pkg::STATUS_OK, 16'h0000, 16'h0000, 0, 0)));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'h00, 1'b0, 1'b1,
                       mk(hsfc_pkg::STATUS_FIRST_BAD, 16'hFFFF, 16'h0000, 0, 0)));
    plan.push_back(row(ROW_BYTE, 8'hA5, 1'b1));
    plan.push_back(row(ROW_MODE, 8'(hsfc_pkg::MODE_MEASURE)));
    // frame start arriving mid-frame restarts assembly
    plan.push_back(row(ROW_BYTE, 8'h55, 1'b1));
    plan.push_back(row(ROW_BYTE, 8'hBE, 1'b1));
    plan.push_back(row(ROW_BYTE, 8'hEF));
    plan.push_back(row(ROW_BYTE, 8'h92));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'hFF));
    plan.push_back(row(ROW_BYTE, 8'h00));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_mode(plan[i].data[0]);
      end else begin
        push_byte(plan[i].data, plan[i].start, plan[i].typed, plan[i].want);
      end
    end

    // random phases, alternating modes; phase 2 runs with no idling on either side
    for (ph = 0; ph < 6; ph++) begin
      set_mode(ph[0] ? hsfc_pkg::MODE_IDENTITY : hsfc_pkg::MODE_MEASURE);
      steady = (ph == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        nwords = (fc_mode == hsfc_pkg::MODE_IDENTITY) ? 1 : 2;
        pick = $urandom_range(99);
        if (pick < 80) begin
          // well-formed frame, occasionally a bad crc or a missing frame start
          for (k = 0; k < nwords; k++) begin
            case ($urandom_range(7))
              0: w = 16'h0000;
              1: w = 16'hFFFF;
              default: w = 16'($urandom);
            endcase
            c = crc_byte(crc_byte(hsfc_pkg::CRC_INIT, w[15:8]), w[7:0]);
            if ($urandom_range(9) == 0) c = c ^ (8'h01 << $urandom_range(7));
            push_byte(w[15:8], (k == 0) && ($urandom_range(9) != 0));
            push_byte(w[7:0], 1'b0);
            push_byte(c, 1'b0);
          end
        end else if (pick < 90) begin
          // truncated frame, dropped by a later frame start or mode write unless bytes with no start complete it
          len = $urandom_range(1, 3 * nwords - 1);
          for (k = 0; k < len; k++) push_byte(8'($urandom), k == 0);
        end else begin
          push_byte(8'($urandom), 1'($urandom_range(1)));
        end
      end
    end

    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d byte items sent, %0d frame results checked, %0d mode writes", bytes_sent,
             results_seen, mode_writes);
    $display("covered both frame modes, crc failures, restarts and truncated frames");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
